>>> hdl/gdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_pkg
// Shared types and constants for the graph traversal engine.
// ----------------------------------------------------------------------------
package gdt_pkg;

    localparam int VERTEX_W = 5;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 6'd32;
    localparam logic [CFG_W-1:0] OMIT_VERTEX_RST  = 6'd32;

    typedef enum logic [1:0] {
        MODE_ADD_EDGE = 2'd0,
        MODE_ISOLATE  = 2'd1,
        MODE_DEPTH    = 2'd2,
        MODE_BREADTH  = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_OMIT_VERTEX  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        mode_t               mode;
        logic [VERTEX_W-1:0] first_vertex;
        logic [VERTEX_W-1:0] second_vertex;
    } in_word_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_id;
        logic                last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0] vertex_count;
        logic [CFG_W-1:0] omit_vertex;
    } cfg_t;

    typedef struct packed {
        logic                push;
        logic                flush;
        logic [VERTEX_W-1:0] vertex;
    } emit_req_t;

endpackage

>>> hdl/gdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/gdt_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_emit
// Holds the most recent visited vertex back by one so that the final vertex
// of a run can be marked, and drives the output register.
// ----------------------------------------------------------------------------
module gdt_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  gdt_pkg::emit_req_t  req,
    output logic                rdy,
    output logic                out_valid,
    input  logic                out_stall,
    output gdt_pkg::out_word_t  out_word
);
    import gdt_pkg::*;

    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [VERTEX_W-1:0] pend_vtx_reg;
    logic [VERTEX_W-1:0] pend_vtx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_word_t           out_word_reg;
    out_word_t           out_word_next;

    assign rdy = !pend_valid_reg || !out_valid_reg || !out_stall;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_vtx_next   = pend_vtx_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (req.push)
        begin
            if (pend_valid_reg)
            begin
                out_word_next.vertex_id   = pend_vtx_reg;
                out_word_next.last_of_run = 1'b0;
                out_valid_next            = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_vtx_next   = req.vertex;
        end
        else if (req.flush && pend_valid_reg)
        begin
            out_word_next.vertex_id   = pend_vtx_reg;
            out_word_next.last_of_run = 1'b1;
            out_valid_next            = 1'b1;
            pend_valid_next           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_vtx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_vtx_reg   <= pend_vtx_next;
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_last_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req.flush && pend_valid_reg && rdy |=> out_valid_reg && out_word_reg.last_of_run)
        else $error("flush of a pending vertex did not produce a marked word");

    a_push_keeps_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req.push && rdy |=> pend_valid_reg && pend_vtx_reg == $past(req.vertex))
        else $error("pushed vertex was not held back");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (req.push || req.flush) |-> rdy)
        else $error("vertex offered while the output side was full");

endmodule

>>> hdl/gdt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_engine
// Command sequencer: adjacency matrix and work list live in two RAMs, edge
// and isolate commands read, modify and write rows, traversals walk them.
// ----------------------------------------------------------------------------
module gdt_engine #(
    parameter int MAX_VERTICES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gdt_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  gdt_pkg::in_word_t  in_word,
    output gdt_pkg::emit_req_t emit_req,
    input  logic               emit_rdy
);
    import gdt_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RA,
        ST_ADD_WA,
        ST_ADD_RB,
        ST_ADD_WB,
        ST_ISO_RD,
        ST_ISO_WR,
        ST_SCAN,
        ST_DFS_ROW,
        ST_DFS_PICK,
        ST_DFS_POP,
        ST_BFS_CHK,
        ST_BFS_WL,
        ST_BFS_ROW,
        ST_BFS_EXP,
        ST_FIN
    } state_t;

    state_t                  state_reg, state_next;
    in_word_t                cmd_reg, cmd_next;
    logic [NW-1:0]           s_reg, s_next;
    logic [NW-1:0]           head_reg, head_next;
    logic [NW-1:0]           tail_reg, tail_next;
    logic [NW-1:0]           iso_reg, iso_next;
    logic [VW-1:0]           top_reg, top_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] cand_reg, cand_next;
    logic [MAX_VERTICES-1:0] adj_vld_reg, adj_vld_next;
    logic                    adj_rvld_reg;

    logic                    adj_we;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    wl_we;
    logic [VW-1:0]           wl_waddr;
    logic [VW-1:0]           wl_wdata;
    logic [VW-1:0]           wl_raddr;
    logic [VW-1:0]           wl_rdata;

    logic [CW-1:0]           vc_ext;
    logic [NW-1:0]           n_lim;
    logic [MAX_VERTICES-1:0] range_mask;
    logic [MAX_VERTICES-1:0] row_data;
    logic [MAX_VERTICES-1:0] dfs_cand;
    logic [VW-1:0]           a_idx;
    logic [VW-1:0]           b_idx;
    logic [VW-1:0]           s_idx;
    logic [VW-1:0]           pick;
    logic [NW-1:0]           tail_m2;
    logic                    a_ok;
    logic                    b_ok;
    logic                    accept;

    gdt_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    gdt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_wl_ram (
        .clk   (clk),
        .we    (wl_we),
        .waddr (wl_waddr),
        .wdata (wl_wdata),
        .raddr (wl_raddr),
        .rdata (wl_rdata)
    );

    function automatic logic [VW-1:0] lowest(input logic [MAX_VERTICES-1:0] m);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic omitted(input logic [VW-1:0] v, input logic [CFG_W-1:0] o);
        return CW'(v) == CW'(o);
    endfunction

    assign vc_ext   = CW'(cfg.vertex_count);
    assign n_lim    = (vc_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_ext);
    assign row_data = adj_rvld_reg ? adj_rdata : '0;
    assign dfs_cand = row_data & range_mask & ~visited_reg;
    assign a_idx    = VW'(cmd_reg.first_vertex);
    assign b_idx    = VW'(cmd_reg.second_vertex);
    assign a_ok     = 32'(cmd_reg.first_vertex) < 32'(MAX_VERTICES);
    assign b_ok     = 32'(cmd_reg.second_vertex) < 32'(MAX_VERTICES);
    assign s_idx    = s_reg[VW-1:0];
    assign tail_m2  = tail_reg - NW'(2);
    assign pick     = (state_reg == ST_BFS_EXP) ? lowest(cand_reg) : lowest(dfs_cand);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            range_mask[i] = NW'(i) < n_lim;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        s_next       = s_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        iso_next     = iso_reg;
        top_next     = top_reg;
        visited_next = visited_reg;
        cand_next    = cand_reg;
        adj_vld_next = adj_vld_reg;
        adj_we       = 1'b0;
        adj_waddr    = a_idx;
        adj_wdata    = '0;
        adj_raddr    = a_idx;
        wl_we        = 1'b0;
        wl_waddr     = tail_reg[VW-1:0];
        wl_wdata     = s_idx;
        wl_raddr     = head_reg[VW-1:0];
        emit_req     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = in_word;
                    s_next       = '0;
                    head_next    = '0;
                    tail_next    = '0;
                    iso_next     = '0;
                    visited_next = '0;
                    case (in_word.mode)
                        MODE_ADD_EDGE: state_next = ST_ADD_RA;
                        MODE_ISOLATE:  state_next = ST_ISO_RD;
                        default:       state_next = ST_SCAN;
                    endcase
                end
            end

            ST_ADD_RA:
            begin
                adj_raddr  = a_idx;
                state_next = (a_ok && b_ok) ? ST_ADD_WA : ST_IDLE;
            end

            ST_ADD_WA:
            begin
                adj_we              = 1'b1;
                adj_waddr           = a_idx;
                adj_wdata           = row_data | (MAX_VERTICES'(1) << b_idx);
                adj_vld_next[a_idx] = 1'b1;
                state_next          = ST_ADD_RB;
            end

            ST_ADD_RB:
            begin
                adj_raddr  = b_idx;
                state_next = ST_ADD_WB;
            end

            ST_ADD_WB:
            begin
                adj_we              = 1'b1;
                adj_waddr           = b_idx;
                adj_wdata           = row_data | (MAX_VERTICES'(1) << a_idx);
                adj_vld_next[b_idx] = 1'b1;
                state_next          = ST_IDLE;
            end

            ST_ISO_RD:
            begin
                adj_raddr  = iso_reg[VW-1:0];
                state_next = a_ok ? ST_ISO_WR : ST_IDLE;
            end

            ST_ISO_WR:
            begin
                adj_we    = 1'b1;
                adj_waddr = iso_reg[VW-1:0];
                if (iso_reg[VW-1:0] == a_idx)
                begin
                    adj_wdata = '0;
                end
                else
                begin
                    adj_wdata = row_data & ~(MAX_VERTICES'(1) << a_idx);
                end
                adj_vld_next[iso_reg[VW-1:0]] = 1'b1;
                iso_next   = iso_reg + NW'(1);
                state_next = (iso_reg == NW'(MAX_VERTICES - 1)) ? ST_IDLE : ST_ISO_RD;
            end

            ST_SCAN:
            begin
                if (s_reg == n_lim)
                begin
                    state_next = ST_FIN;
                end
                else if (visited_reg[s_idx])
                begin
                    s_next = s_reg + NW'(1);
                end
                else if (emit_rdy)
                begin
                    visited_next[s_idx] = 1'b1;
                    emit_req.push       = !omitted(s_idx, cfg.omit_vertex);
                    emit_req.vertex     = VERTEX_W'(s_idx);
                    wl_wdata            = s_idx;
                    if (cmd_reg.mode == MODE_DEPTH)
                    begin
                        wl_we      = 1'b1;
                        wl_waddr   = '0;
                        tail_next  = NW'(1);
                        top_next   = s_idx;
                        state_next = ST_DFS_ROW;
                    end
                    else
                    begin
                        if (tail_reg < NW'(MAX_VERTICES))
                        begin
                            wl_we     = 1'b1;
                            tail_next = tail_reg + NW'(1);
                        end
                        state_next = ST_BFS_CHK;
                    end
                end
            end

            ST_DFS_ROW:
            begin
                adj_raddr  = top_reg;
                state_next = ST_DFS_PICK;
            end

            ST_DFS_PICK:
            begin
                adj_raddr = top_reg;
                if (|dfs_cand)
                begin
                    if (emit_rdy)
                    begin
                        visited_next[pick] = 1'b1;
                        emit_req.push      = !omitted(pick, cfg.omit_vertex);
                        emit_req.vertex    = VERTEX_W'(pick);
                        if (tail_reg < NW'(MAX_VERTICES))
                        begin
                            wl_we     = 1'b1;
                            wl_wdata  = pick;
                            tail_next = tail_reg + NW'(1);
                            top_next  = pick;
                        end
                        state_next = ST_DFS_ROW;
                    end
                end
                else
                begin
                    tail_next = tail_reg - NW'(1);
                    if (tail_reg == NW'(1))
                    begin
                        s_next     = s_reg + NW'(1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        wl_raddr   = tail_m2[VW-1:0];
                        state_next = ST_DFS_POP;
                    end
                end
            end

            ST_DFS_POP:
            begin
                top_next   = wl_rdata;
                state_next = ST_DFS_ROW;
            end

            ST_BFS_CHK:
            begin
                if (head_reg == tail_reg)
                begin
                    s_next     = s_reg + NW'(1);
                    state_next = ST_SCAN;
                end
                else
                begin
                    wl_raddr   = head_reg[VW-1:0];
                    state_next = ST_BFS_WL;
                end
            end

            ST_BFS_WL:
            begin
                adj_raddr  = wl_rdata;
                head_next  = head_reg + NW'(1);
                state_next = ST_BFS_ROW;
            end

            ST_BFS_ROW:
            begin
                cand_next  = row_data & range_mask & ~visited_reg;
                state_next = ST_BFS_EXP;
            end

            ST_BFS_EXP:
            begin
                if (cand_reg == '0)
                begin
                    state_next = ST_BFS_CHK;
                end
                else if (emit_rdy)
                begin
                    cand_next[pick]    = 1'b0;
                    visited_next[pick] = 1'b1;
                    emit_req.push      = !omitted(pick, cfg.omit_vertex);
                    emit_req.vertex    = VERTEX_W'(pick);
                    if (tail_reg < NW'(MAX_VERTICES))
                    begin
                        wl_we     = 1'b1;
                        wl_wdata  = pick;
                        tail_next = tail_reg + NW'(1);
                    end
                end
            end

            ST_FIN:
            begin
                emit_req.flush = emit_rdy;
                if (emit_rdy)
                begin
                    head_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= '0;
            s_reg        <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            iso_reg      <= '0;
            top_reg      <= '0;
            visited_reg  <= '0;
            cand_reg     <= '0;
            adj_vld_reg  <= '0;
            adj_rvld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            s_reg        <= s_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            iso_reg      <= iso_next;
            top_reg      <= top_next;
            visited_reg  <= visited_next;
            cand_reg     <= cand_next;
            adj_vld_reg  <= adj_vld_next;
            adj_rvld_reg <= adj_vld_reg[adj_raddr];
        end
    end

    a_tail_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= NW'(MAX_VERTICES))
        else $error("work list overran its depth");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BFS_CHK |-> head_reg <= tail_reg)
        else $error("queue head passed its tail");

    a_visited_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (visited_reg & ~range_mask) == '0)
        else $error("vertex outside the active range was visited");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_req.push || emit_req.flush) |-> emit_rdy)
        else $error("vertex offered to a full output stage");

endmodule

>>> hdl/graph_dfs_bfs_traversal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_bfs_traversal_top
// Undirected graph kept as a bit adjacency matrix, with depth-first and
// breadth-first traversal commands.
// ----------------------------------------------------------------------------
// Each input word is one command, and the block takes no new word until the
// command is done. Add edge and isolate commands are bound by the single
// read port of the adjacency RAM, since every row update reads its row
// before it writes it back. In a traversal, each visited vertex costs at
// least one adjacency row read plus a pick of the lowest unvisited
// neighbor, each work list step costs one more read of the work list RAM,
// and the scan for new start vertices steps through every active vertex; a
// stalled output holds the search. Output words arrive one vertex behind
// the search so that the final one carries last_of_run. The adjacency
// matrix reads as all zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_traversal_top #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  gdt_pkg::cfg_index_t       cfg_index,
    input  logic [gdt_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gdt_pkg::in_word_t         in_word,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gdt_pkg::out_word_t        out_word
);
    import gdt_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    emit_req_t emit_req;
    logic      emit_rdy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: cfg_next.vertex_count = cfg_data;
                CFG_OMIT_VERTEX:  cfg_next.omit_vertex  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_count <= VERTEX_COUNT_RST;
            cfg_reg.omit_vertex  <= OMIT_VERTEX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gdt_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .emit_req (emit_req),
        .emit_rdy (emit_rdy)
    );

    gdt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (emit_req),
        .rdy       (emit_rdy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

>>> test/gdt_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_walk_checker
// Keeps its own copy of the graph and settings, predicts the vertex words of
// every traversal command, and checks each vertex word against the oldest
// prediction.
// ----------------------------------------------------------------------------
module gdt_walk_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  gdt_pkg::cfg_index_t       cfg_index,
    input  logic [gdt_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  gdt_pkg::in_word_t         in_word,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  gdt_pkg::out_word_t        out_word,
    output int                        errors,
    output int                        awaiting
);

    import gdt_pkg::*;

    logic [31:0]      adj_rows [32];
    logic [CFG_W-1:0] span_count;
    logic [CFG_W-1:0] omit_id;
    out_word_t        walk_q [$];
    int               err_total = 0;
    int               pending_n = 0;

    assign errors   = err_total;
    assign awaiting = pending_n;

    task automatic report_mismatch(input string what);
        $display("gdt_walk_checker: mismatch: %s", what);
        err_total++;
    endtask

    function automatic void plan_walk(input logic breadth);
        logic [31:0] seen;
        logic [31:0] span;
        logic [31:0] cand;
        logic [4:0]  at;
        logic [4:0]  trail [$];
        logic [4:0]  order [$];
        logic [4:0]  shown [$];
        out_word_t   w;
        int          n;
        int          pick;
        seen = '0;
        n = (span_count > 6'd32) ? 32 : int'(span_count);
        span = (n == 32) ? '1 : ((32'd1 << n) - 32'd1);
        for (int s = 0; s < n; s++) begin
            if (!seen[s]) begin
                seen[s] = 1'b1;
                order.push_back(5'(s));
                trail.push_back(5'(s));
                while (trail.size() != 0) begin
                    if (breadth) begin
                        at = trail.pop_front();
                        cand = adj_rows[at] & span & ~seen;
                        for (int k = 0; k < 32; k++) begin
                            if (cand[k]) begin
                                seen[k] = 1'b1;
                                order.push_back(5'(k));
                                trail.push_back(5'(k));
                            end
                        end
                    end
                    else begin
                        at = trail[trail.size() - 1];
                        cand = adj_rows[at] & span & ~seen;
                        if (cand != 0) begin
                            pick = 0;
                            for (int k = 31; k >= 0; k--) begin
                                if (cand[k]) pick = k;
                            end
                            seen[pick] = 1'b1;
                            order.push_back(5'(pick));
                            trail.push_back(5'(pick));
                        end
                        else begin
                            void'(trail.pop_back());
                        end
                    end
                end
            end
        end
        // The omitted vertex is still walked through, it just never shows up.
        foreach (order[i]) begin
            if ({1'b0, order[i]} != omit_id) shown.push_back(order[i]);
        end
        foreach (shown[i]) begin
            w.vertex_id   = shown[i];
            w.last_of_run = (i == shown.size() - 1);
            walk_q.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        in_word_t  cmd;
        if (!rst_n) begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
            span_count = VERTEX_COUNT_RST;
            omit_id    = OMIT_VERTEX_RST;
            walk_q.delete();
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: span_count = cfg_data;
                    CFG_OMIT_VERTEX:  omit_id    = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (walk_q.size() == 0) begin
                    report_mismatch($sformatf("vertex %0d arrived with nothing expected",
                                              out_word.vertex_id));
                end
                else begin
                    want = walk_q.pop_front();
                    if (out_word.vertex_id !== want.vertex_id)
                        report_mismatch($sformatf("vertex_id %0d, expected %0d",
                                                  out_word.vertex_id, want.vertex_id));
                    if (out_word.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b on vertex %0d, expected %0b",
                                                  out_word.last_of_run, want.vertex_id,
                                                  want.last_of_run));
                end
            end
            if (in_valid && !in_stall) begin
                cmd = in_word;
                case (cmd.mode)
                    MODE_ADD_EDGE:
                    begin
                        adj_rows[cmd.first_vertex][cmd.second_vertex] = 1'b1;
                        adj_rows[cmd.second_vertex][cmd.first_vertex] = 1'b1;
                    end
                    MODE_ISOLATE:
                    begin
                        adj_rows[cmd.first_vertex] = '0;
                        foreach (adj_rows[i]) adj_rows[i][cmd.first_vertex] = 1'b0;
                    end
                    MODE_DEPTH:   plan_walk(1'b0);
                    MODE_BREADTH: plan_walk(1'b1);
                    default: ;
                endcase
            end
        end
        pending_n = walk_q.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the graph traversal engine with directed and random command words
// under changing idle patterns and settings, and gives the final verdict.
// ----------------------------------------------------------------------------
module tb;

    import gdt_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int QUIET_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    cfg_index_t       cfg_index = CFG_VERTEX_COUNT;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_word_t         in_word   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_word_t        out_word;
    int               errors;
    int               awaiting;

    int tx_idle     = 0;
    int rx_idle     = 0;
    int hold_asks   = 0;
    int hold_done   = 0;
    int hold_left   = 0;
    int cycle_count = 0;
    int cur_count   = 32;

    graph_dfs_bfs_traversal_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    gdt_walk_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .errors    (errors),
        .awaiting  (awaiting)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // A long hold keeps the vertex channel blocked so the engine backs up.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
        else begin
            out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    task automatic send_word(input mode_t mode, input logic [4:0] a, input logic [4:0] b);
        in_word_t w;
        w.mode          = mode;
        w.first_vertex  = a;
        w.second_vertex = b;
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_set(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_VERTEX_COUNT) cur_count = int'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word();
        int          r;
        int          lim;
        logic [4:0]  a;
        logic [4:0]  b;
        r = $urandom_range(99);
        lim = (cur_count == 0 || cur_count > 32) ? 32 : cur_count;
        a = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(lim - 1));
        b = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(lim - 1));
        if (r < 55)
            send_word(MODE_ADD_EDGE, a, b);
        else if (r < 63)
            send_word(MODE_ISOLATE, a, b);
        else if (r < 82)
            send_word(MODE_DEPTH, a, b);
        else
            send_word(MODE_BREADTH, a, b);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 7;
        rx_idle = 82;
        send_word(MODE_DEPTH, 5'd0, 5'd0);
        send_word(MODE_ADD_EDGE, 5'd0, 5'd31);
        send_word(MODE_ADD_EDGE, 5'd31, 5'd5);
        send_word(MODE_ADD_EDGE, 5'd5, 5'd5);
        send_word(MODE_ADD_EDGE, 5'd3, 5'd31);
        send_word(MODE_ADD_EDGE, 5'd2, 5'd4);
        send_word(MODE_ADD_EDGE, 5'd4, 5'd6);
        send_word(MODE_ADD_EDGE, 5'd6, 5'd2);
        send_word(MODE_ADD_EDGE, 5'd1, 5'd30);
        send_word(MODE_DEPTH, 5'd31, 5'd31);
        send_word(MODE_BREADTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_OMIT_VERTEX, 6'd0);
        send_word(MODE_DEPTH, 5'd0, 5'd0);
        send_word(MODE_BREADTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_OMIT_VERTEX, 6'd31);
        send_word(MODE_ISOLATE, 5'd31, 5'd0);
        send_word(MODE_BREADTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_VERTEX_COUNT, 6'd6);
        cfg_set(CFG_OMIT_VERTEX, 6'd32);
        send_word(MODE_ADD_EDGE, 5'd4, 5'd20);
        send_word(MODE_DEPTH, 5'd0, 5'd0);
        send_word(MODE_ISOLATE, 5'd20, 5'd0);
        send_word(MODE_BREADTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_VERTEX_COUNT, 6'd1);
        send_word(MODE_DEPTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_OMIT_VERTEX, 6'd0);
        send_word(MODE_BREADTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_VERTEX_COUNT, 6'd0);
        cfg_set(CFG_OMIT_VERTEX, 6'd32);
        send_word(MODE_DEPTH, 5'd0, 5'd0);
        settle();
        cfg_set(CFG_VERTEX_COUNT, 6'd63);
        cfg_set(CFG_OMIT_VERTEX, 6'd63);
        send_word(MODE_BREADTH, 5'd0, 5'd0);
        send_word(MODE_DEPTH, 5'd0, 5'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:
                begin
                    tx_idle = 7;
                    rx_idle = 82;
                end
                1:
                begin
                    tx_idle = 82;
                    rx_idle = 7;
                end
                default:
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            for (int round = 0; round < 4; round++) begin
                settle();
                case ($urandom_range(5))
                    0:       cfg_set(CFG_VERTEX_COUNT, 6'd32);
                    1:       cfg_set(CFG_VERTEX_COUNT, 6'($urandom_range(1, 4)));
                    2:       cfg_set(CFG_VERTEX_COUNT, 6'($urandom_range(63)));
                    default: cfg_set(CFG_VERTEX_COUNT, 6'($urandom_range(5, 32)));
                endcase
                if ($urandom_range(3) == 0)
                    cfg_set(CFG_OMIT_VERTEX, 6'($urandom_range(63)));
                else
                    cfg_set(CFG_OMIT_VERTEX,
                            6'($urandom_range(cur_count > 32 ? 32 : cur_count)));
                if (phase == 0 && round == 1) begin
                    hold_asks++;
                    send_word(MODE_DEPTH, 5'd0, 5'd0);
                end
                for (int k = 0; k < 21; k++) random_word();
            end
        end

        settle();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
